>>> design/lpbd_pkg.sv
// Package for the length-prefixed backup deframer.
// Holds the parse phase type, the result beat type and the length-field constant.
// No dependencies.
package lpbd_pkg;

	localparam int unsigned LENGTH_BYTES_DEF = 8;

	typedef enum logic [2:0] {
		PH_SKIP     = 3'd0,
		PH_COUNT    = 3'd1,
		PH_META_LEN = 3'd2,
		PH_META     = 3'd3,
		PH_DATA_LEN = 3'd4,
		PH_DATA     = 3'd5,
		PH_DONE     = 3'd6
	} phase_t;

	typedef struct packed {
		logic       payload_valid;
		logic       payload_target;
		logic [7:0] payload_byte;
		logic       file_last;
		logic       transfer_done;
	} res_t;

endpackage

>>> design/lpbd_parser.sv
// Stream parser: skip counter, header fields, length accumulator and payload counter.
// Produces one result beat per stepped byte. Depends on lpbd_pkg.
module lpbd_parser #(
	parameter int unsigned LENGTH_BYTES = lpbd_pkg::LENGTH_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_skip,
	output lpbd_pkg::res_t    res
);
	import lpbd_pkg::*;

	localparam int unsigned LEN_W = 8 * LENGTH_BYTES;
	localparam int unsigned REM_W = (LEN_W > 16) ? LEN_W : 16;
	localparam int unsigned IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

	phase_t             phase_q, phase_n;
	logic [REM_W-1:0]   rem_q, rem_n;
	logic [LEN_W-1:0]   len_q, len_n, len_new;
	logic [IDX_W-1:0]   idx_q, idx_n;
	logic               one_q, one_n;
	logic               rem_zero, rem_le1, idx_last, len_zero;

	assign rem_zero = (rem_q == '0);
	assign rem_le1  = ((rem_q >> 1) == '0);
	assign idx_last = (idx_q == IDX_W'(LENGTH_BYTES - 1));
	assign len_zero = (len_new == '0);

	always_comb begin
		len_new = len_q;
		for (int i = 0; i < LENGTH_BYTES; i++) begin
			if (idx_q == IDX_W'(i)) begin
				len_new[8*i +: 8] = byte_in;
			end
		end
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		rem_n   = rem_q;
		len_n   = len_q;
		idx_n   = idx_q;
		one_n   = one_q;
		case (phase_q)
			PH_SKIP, PH_COUNT: begin
				if (phase_q == PH_SKIP && !rem_zero) begin
					rem_n = rem_q - REM_W'(1);
					if (rem_le1) begin
						phase_n = PH_COUNT;
					end
				end else begin
					one_n   = (byte_in == 8'd1);
					phase_n = PH_META_LEN;
					idx_n   = '0;
					len_n   = '0;
				end
			end
			PH_META_LEN, PH_DATA_LEN: begin
				len_n = len_new;
				idx_n = idx_q + IDX_W'(1);
				if (idx_last) begin
					if (len_zero) begin
						phase_n = (phase_q == PH_META_LEN) ? PH_DATA_LEN : PH_DONE;
						idx_n   = '0;
						len_n   = '0;
					end else begin
						phase_n = (phase_q == PH_META_LEN) ? PH_META : PH_DATA;
						rem_n   = REM_W'(len_new);
					end
				end
			end
			PH_META, PH_DATA: begin
				if (!rem_zero) begin
					rem_n = rem_q - REM_W'(1);
				end
				if (rem_le1) begin
					phase_n = (phase_q == PH_META) ? PH_DATA_LEN : PH_DONE;
					idx_n   = '0;
					len_n   = '0;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
	end

	// result beat
	always_comb begin
		res = '0;
		case (phase_q)
			PH_META_LEN: begin
				res.file_last     = idx_last && len_zero;
				res.transfer_done = idx_last && len_zero && one_q;
			end
			PH_META: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = byte_in;
				res.file_last     = rem_le1;
				res.transfer_done = rem_le1 && one_q;
			end
			PH_DATA_LEN: begin
				res.payload_target = idx_last && len_zero;
				res.file_last      = idx_last && len_zero;
				res.transfer_done  = idx_last && len_zero && !one_q;
			end
			PH_DATA: begin
				res.payload_valid  = 1'b1;
				res.payload_target = 1'b1;
				res.payload_byte   = byte_in;
				res.file_last      = rem_le1;
				res.transfer_done  = rem_le1 && !one_q;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			rem_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			one_q   <= 1'b0;
		end else if (cfg_we) begin
			if (phase_q == PH_SKIP) begin
				rem_q <= REM_W'(cfg_skip);
			end
		end else if (step) begin
			phase_q <= phase_n;
			rem_q   <= rem_n;
			len_q   <= len_n;
			idx_q   <= idx_n;
			one_q   <= one_n;
		end
	end

endmodule

>>> design/lpbd_out_stage.sv
// Result register of the deframer: holds one result beat until it is taken.
// Depends on lpbd_pkg.
module lpbd_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           valid_d,
	input  lpbd_pkg::res_t res_d,
	output logic           valid,
	output lpbd_pkg::res_t res
);
	import lpbd_pkg::*;

	logic valid_s2;
	res_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid_d) begin
			res_s2 <= res_d;
		end
	end

	assign valid = valid_s2;
	assign res   = res_s2;

endmodule

>>> design/length_prefixed_backup_deframer_core.sv
// Top level of the length-prefixed backup deframer: input register, parser, result register.
// Depends on lpbd_pkg, lpbd_parser and lpbd_out_stage.
//
//   channel  | handshake            | beat
//   ---------+----------------------+----------------------------------------------
//   in       | in_valid / in_stall  | data_byte
//   out      | out_valid / out_stall| payload_valid, payload_target, payload_byte,
//            |                      | file_last, transfer_done
//   cfg      | cfg_valid / cfg_ready| skip_length
//
// One byte per cycle while the result is not stalled; each byte passes the input register,
// then parse logic into the result register. The 64-bit remaining counter decrement
// sets the critical path. Reset clears phase and counters; skip count resets to zero.
// A stalled result holds the result register and, through it, the input register.
// Hold skip-count writes while a byte waits in the input register.
module length_prefixed_backup_deframer_core #(
	parameter int unsigned LENGTH_BYTES = lpbd_pkg::LENGTH_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic        payload_target,
	output logic [7:0]  payload_byte,
	output logic        file_last,
	output logic        transfer_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] skip_length
);
	import lpbd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	res_t       res_c, res_o;

	assign adv       = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	lpbd_parser #(
		.LENGTH_BYTES(LENGTH_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && adv),
		.byte_in (byte_s1),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_skip(skip_length),
		.res     (res_c)
	);

	lpbd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.valid_d(valid_s1),
		.res_d  (res_c),
		.valid  (out_valid),
		.res    (res_o)
	);

	assign payload_valid  = res_o.payload_valid;
	assign payload_target = res_o.payload_target;
	assign payload_byte   = res_o.payload_byte;
	assign file_last      = res_o.file_last;
	assign transfer_done  = res_o.transfer_done;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_done |-> file_last)
		else $error("transfer_done without file_last");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("payload_byte non-zero on a beat without payload");

	a_stall_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result register can advance");

endmodule

>>> tb/sv/lpbd_result_check.sv
// Result checker for the length-prefixed backup deframer testbench.
// Watches the byte, result and skip-count channels, predicts each result beat and compares.
// Depends on lpbd_pkg only.
module lpbd_result_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        payload_valid,
	input  logic        payload_target,
	input  logic [7:0]  payload_byte,
	input  logic        file_last,
	input  logic        transfer_done,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] skip_length,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import lpbd_pkg::*;

	localparam int unsigned LEN = LENGTH_BYTES_DEF;

	logic [15:0] skip_reg;
	phase_t      stage;
	logic [63:0] left;
	logic [7:0]  files;
	logic [63:0] meta_len;
	logic [63:0] data_len;
	res_t        awaited_results[$];

	function automatic logic [63:0] place_length_byte(input logic [63:0] acc,
			input logic [7:0] b);
		logic [63:0] pos;
		pos = (64'(LEN) - left) & 64'd7;
		return acc | (64'(b) << (pos * 8));
	endfunction

	function automatic res_t deframe_byte(input logic [7:0] b);
		res_t   r;
		phase_t ph;
		r = '0;
		ph = stage;
		if (ph == PH_SKIP) begin
			if (left != 0) begin
				left = left - 1;
				if (left == 0) begin
					stage = PH_COUNT;
					left = 64'd1;
				end
			end else begin
				ph = PH_COUNT;
			end
		end
		case (ph)
			PH_COUNT: begin
				files = b;
				stage = PH_META_LEN;
				left = 64'(LEN);
				meta_len = '0;
			end
			PH_META_LEN: begin
				if (left == 0 || left > LEN)
					left = 64'(LEN);
				meta_len = place_length_byte(meta_len, b);
				left = left - 1;
				if (left == 0) begin
					if (meta_len == 0) begin
						r.file_last = 1'b1;
						r.transfer_done = (files == 8'd1);
						stage = PH_DATA_LEN;
						left = 64'(LEN);
						data_len = '0;
					end else begin
						stage = PH_META;
						left = meta_len;
					end
				end
			end
			PH_META: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				if (left != 0)
					left = left - 1;
				if (left == 0) begin
					r.file_last = 1'b1;
					r.transfer_done = (files == 8'd1);
					stage = PH_DATA_LEN;
					left = 64'(LEN);
					data_len = '0;
				end
			end
			PH_DATA_LEN: begin
				if (left == 0 || left > LEN)
					left = 64'(LEN);
				data_len = place_length_byte(data_len, b);
				left = left - 1;
				if (left == 0) begin
					if (data_len == 0) begin
						r.payload_target = 1'b1;
						r.file_last = 1'b1;
						r.transfer_done = (files != 8'd1);
						stage = PH_DONE;
					end else begin
						stage = PH_DATA;
						left = data_len;
					end
				end
			end
			PH_DATA: begin
				r.payload_valid = 1'b1;
				r.payload_target = 1'b1;
				r.payload_byte = b;
				if (left != 0)
					left = left - 1;
				if (left == 0) begin
					r.file_last = 1'b1;
					r.transfer_done = (files != 8'd1);
					stage = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			skip_reg = '0;
			stage = PH_SKIP;
			left = '0;
			files = '0;
			meta_len = '0;
			data_len = '0;
			awaited_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with nothing outstanding");
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("payload_valid", 8'(want.payload_valid),
						8'(payload_valid));
					check_field("payload_target", 8'(want.payload_target),
						8'(payload_target));
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("file_last", 8'(want.file_last), 8'(file_last));
					check_field("transfer_done", 8'(want.transfer_done),
						8'(transfer_done));
				end
			end
			if (cfg_valid && cfg_ready) begin
				skip_reg = skip_length;
				if (stage == PH_SKIP)
					left = 64'(skip_reg);
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(deframe_byte(data_byte));
			outstanding = awaited_results.size();
		end
	end

endmodule

>>> tb/sv/tb_length_prefixed_backup_deframer_core.sv
// Testbench top for length_prefixed_backup_deframer_core: drives one framed transfer
// with skip-count changes, random gaps and stalls, and gives the verdict.
// Depends on lpbd_pkg, the block and lpbd_result_check.
module tb_length_prefixed_backup_deframer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lpbd_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic        payload_valid;
	logic        payload_target;
	logic [7:0]  payload_byte;
	logic        file_last;
	logic        transfer_done;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] skip_length;
	int          fail_count;
	int          pending;
	bit          calm = 1'b0;
	int          quiet_cycles = 0;

	length_prefixed_backup_deframer_core dut (.*);

	lpbd_result_check u_check (
		.mismatches (fail_count),
		.outstanding(pending),
		.*
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_length(input logic [63:0] len);
		for (int i = 0; i < 8; i++)
			send_byte(len[8*i +: 8]);
	endtask

	task automatic send_payload(input longint n);
		logic [7:0] b;
		for (longint i = 0; i < n; i++) begin
			calm = (i >= 200 && i < 400);
			b = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
			send_byte(b);
		end
		calm = 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_skip(input logic [15:0] v);
		cfg_valid <= 1'b1;
		skip_length <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 8)) @(negedge clk) out_stall <= 1'b0;
			hold = pick_gap();
			repeat (hold) @(negedge clk) out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("[length_prefixed_backup_deframer_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [63:0] meta_len;
		logic [63:0] data_len;
		logic [7:0]  count;
		int          skip_n;
		bit          huge;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		cfg_valid = 1'b0;
		skip_length = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// widest skip first, then reload a short one
		write_skip(16'hFFFF);
		repeat (3) send_byte(8'($urandom));
		wait_idle();
		skip_n = $urandom_range(2, 6);
		write_skip(16'(skip_n));
		repeat (skip_n - 1) send_byte(8'($urandom));
		if ($urandom_range(0, 1)) begin
			wait_idle();
			write_skip(16'd0);
		end else begin
			send_byte(8'($urandom));
		end

		case ($urandom_range(0, 3))
			0: count = 8'd1;
			1: count = 8'd0;
			2: count = 8'hFF;
			default: count = 8'($urandom);
		endcase
		send_byte(count);

		huge = 1'b0;
		case ($urandom_range(0, 7))
			0: begin
				meta_len = '0;
				data_len = 64'd1650;
			end
			1: begin
				meta_len = 64'd1650;
				data_len = '0;
			end
			2: begin
				huge = 1'b1;
				meta_len = 64'($urandom_range(50, 300));
				data_len = {$urandom, $urandom};
				data_len[63] = 1'b1;
			end
			default: begin
				meta_len = 64'($urandom_range(1, 600));
				data_len = 64'd1650 - meta_len;
			end
		endcase

		send_length(meta_len);
		wait_idle();
		write_skip(16'hFFFF);
		send_payload(longint'(meta_len));
		wait_idle();
		write_skip(16'($urandom));
		send_length(data_len);
		send_payload(huge ? 64'd1500 : longint'(data_len));

		// trailing bytes after the transfer
		if (!huge) begin
			wait_idle();
			write_skip(16'd0);
			repeat (30) send_byte(8'($urandom));
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[length_prefixed_backup_deframer_core] OK");
		else
			$display("[length_prefixed_backup_deframer_core] ERROR");
		$finish;
	end

endmodule
